[rtl/spq_pkg.sv]
`default_nettype none
package spq_pkg;

  localparam int PRIO_W       = 10;
  localparam int ID_W         = 30;
  localparam int AGE_W        = 8;
  localparam int OCC_W        = 5;
  localparam int CAPACITY_DEF = 16;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic              req_type;
    logic [PRIO_W-1:0] priority_req;
    logic [ID_W-1:0]   entry_id;
    logic [AGE_W-1:0]  age;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [PRIO_W-1:0] out_priority;
    logic [ID_W-1:0]   out_id;
    logic [AGE_W-1:0]  out_age;
    logic [OCC_W-1:0]  occupancy;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage
`default_nettype wire

[rtl/spq_datapath.sv]
`default_nettype none
module spq_datapath
  import spq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t cmd,
  input  wire req_t req,
  output res_t      result
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  req_t              req_q;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [PRIO_W-1:0] slot_priority [CAPACITY];
  logic [ID_W-1:0]   slot_id       [CAPACITY];
  logic [AGE_W-1:0]  slot_age      [CAPACITY];
  logic [CAPACITY-1:0] ge;
  logic              empty;
  logic              full;
  logic              do_insert;
  logic              do_remove;
  res_t              res_next;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
  end

  always_comb begin
    empty     = (count == '0);
    full      = (count == CNT_W'(CAPACITY));
    do_insert = cmd.exec && !req_q.req_type && !full;
    do_remove = cmd.exec && req_q.req_type && !empty;
    count_next = count;
    if (do_insert) begin
      count_next = count + CNT_W'(1);
    end else if (do_remove) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_comb begin
    res_next              = '0;
    res_next.status       = ST_OK;
    res_next.occupancy    = OCC_W'(count_next);
    if (req_q.req_type) begin
      if (empty) begin
        res_next.status = ST_EMPTY;
      end else begin
        res_next.out_priority = slot_priority[0];
        res_next.out_id       = slot_id[0];
        res_next.out_age      = slot_age[0];
      end
    end else if (full) begin
      res_next.status = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      result <= res_next;
    end
  end

  // one cell per slot: each compares itself with the new priority and
  // looks at its neighbor to decide hold, load or shift
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic prev_ge;

    assign ge[i] = (CNT_W'(i) < count) && (slot_priority[i] >= req_q.priority_req);

    if (i == 0) begin : g_head
      assign prev_ge = 1'b1;
    end else begin : g_body
      assign prev_ge = ge[i-1];
    end

    always_ff @(posedge clk) begin
      if (do_insert && !ge[i]) begin
        if (prev_ge) begin
          slot_priority[i] <= req_q.priority_req;
          slot_id[i]       <= req_q.entry_id;
          slot_age[i]      <= req_q.age;
        end else if (i > 0) begin
          slot_priority[i] <= slot_priority[(i > 0) ? i-1 : 0];
          slot_id[i]       <= slot_id[(i > 0) ? i-1 : 0];
          slot_age[i]      <= slot_age[(i > 0) ? i-1 : 0];
        end
      end else if (do_remove && (i < CAPACITY - 1)) begin
        slot_priority[i] <= slot_priority[(i < CAPACITY - 1) ? i+1 : i];
        slot_id[i]       <= slot_id[(i < CAPACITY - 1) ? i+1 : i];
        slot_age[i]      <= slot_age[(i < CAPACITY - 1) ? i+1 : i];
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  assert property (@(posedge clk) disable iff (rst)
    do_remove |=> count == $past(count) - CNT_W'(1))
    else $error("remove did not drop the fill count");

  assert property (@(posedge clk) disable iff (rst)
    cmd.exec && !req_q.req_type && full |=> $stable(count))
    else $error("refused insert changed the fill count");

endmodule
`default_nettype wire

[rtl/spq_ctrl.sv]
`default_nettype none
module spq_ctrl
  import spq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  output logic      done,
  output cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    busy     = (state == S_EXEC);
    cmd.load = start && !busy;
    cmd.exec = (state == S_EXEC);
    case (state)
      S_IDLE:  state_next = cmd.load ? S_EXEC : S_IDLE;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.exec;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not start work");

  assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy && done)
    else $error("work did not finish with a result strobe");

  assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule
`default_nettype wire

[rtl/stable_priority_queue_core.sv]
`default_nettype none
// Sorted priority queue of up to CAPACITY entries, highest priority at the head
// and equal priorities kept in arrival order. A request is taken when start is
// high and busy is low; busy then stays high for one cycle while every slot
// compares itself with the request and shifts in place, and the result is on
// result with done high in the cycle after that. The receiver cannot stall:
// done is a one-cycle strobe and the result must be taken then. An insert into
// a full queue returns a full status and changes nothing; a remove from an
// empty queue returns an empty status.
module stable_priority_queue_core
  import spq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req,
  output logic      done,
  output res_t      result
);

  cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .req    (req),
    .result (result)
  );

endmodule
`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import spq_pkg::*;

  localparam bit REQ_INSERT = 1'b0;
  localparam bit REQ_REMOVE = 1'b1;
  localparam int QDEPTH     = CAPACITY_DEF;
  localparam int N_RANDOM   = 850;

  logic clk;
  logic rst   = 1'b1;
  logic start = 1'b0;
  req_t req   = '0;
  logic busy;
  logic done;
  res_t result;

  stable_priority_queue_core #(
    .CAPACITY(QDEPTH)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // shadow copy of the sorted slots, head at index 0
  logic [PRIO_W-1:0] shadow_prio [QDEPTH];
  logic [ID_W-1:0]   shadow_id   [QDEPTH];
  logic [AGE_W-1:0]  shadow_age  [QDEPTH];
  int                shadow_fill = 0;

  res_t pending_results[$];
  int   err_cnt = 0;

  typedef struct {
    req_t rq;
    bit   known;
    res_t res;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic res_t sorted_queue_step(req_t r);
    res_t o;
    int   pos;
    o = '0;
    if (r.req_type == REQ_REMOVE) begin
      if (shadow_fill == 0) begin
        o.status = ST_EMPTY;
      end else begin
        o.status       = ST_OK;
        o.out_priority = shadow_prio[0];
        o.out_id       = shadow_id[0];
        o.out_age      = shadow_age[0];
        for (int i = 1; i < shadow_fill; i++) begin
          shadow_prio[i-1] = shadow_prio[i];
          shadow_id[i-1]   = shadow_id[i];
          shadow_age[i-1]  = shadow_age[i];
        end
        shadow_fill--;
      end
    end else if (shadow_fill >= QDEPTH) begin
      o.status = ST_FULL;
    end else begin
      o.status = ST_OK;
      // new entry goes in front of the first strictly lower priority
      pos = shadow_fill;
      for (int i = 0; i < shadow_fill; i++) begin
        if (shadow_prio[i] < r.priority_req) begin
          pos = i;
          break;
        end
      end
      for (int i = shadow_fill; i > pos; i--) begin
        shadow_prio[i] = shadow_prio[i-1];
        shadow_id[i]   = shadow_id[i-1];
        shadow_age[i]  = shadow_age[i-1];
      end
      shadow_prio[pos] = r.priority_req;
      shadow_id[pos]   = r.entry_id;
      shadow_age[pos]  = r.age;
      shadow_fill++;
    end
    o.occupancy = shadow_fill[OCC_W-1:0];
    return o;
  endfunction

  function automatic void add_row(bit rtype, int p, int id, int a, bit known,
                                  status_t st, int occ);
    dir_row_t row;
    row.rq.req_type     = rtype;
    row.rq.priority_req = p[PRIO_W-1:0];
    row.rq.entry_id     = id[ID_W-1:0];
    row.rq.age          = a[AGE_W-1:0];
    row.known           = known;
    row.res             = '0;
    row.res.status      = st;
    row.res.occupancy   = occ[OCC_W-1:0];
    dir_rows.push_back(row);
  endfunction

  // offer one transaction, hold it until taken, then queue its expected result
  task automatic issue_request(req_t r, bit known, res_t known_res, int idle_pct);
    res_t pred;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    pred = sorted_queue_step(r);
    pending_results.push_back(known ? known_res : pred);
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction, actual %p", $time, result);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, result.status);
          err_cnt++;
        end
        if (result.out_priority !== want.out_priority) begin
          $display("%0t: out_priority expected %0d actual %0d", $time,
                   want.out_priority, result.out_priority);
          err_cnt++;
        end
        if (result.out_id !== want.out_id) begin
          $display("%0t: out_id expected %0d actual %0d", $time, want.out_id, result.out_id);
          err_cnt++;
        end
        if (result.out_age !== want.out_age) begin
          $display("%0t: out_age expected %0d actual %0d", $time, want.out_age, result.out_age);
          err_cnt++;
        end
        if (result.occupancy !== want.occupancy) begin
          $display("%0t: occupancy expected %0d actual %0d", $time,
                   want.occupancy, result.occupancy);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int   idle_pct [4];
    int   ins_pct;
    int   guard;
    int   phase;
    req_t r;

    idle_pct = '{0, 57, 0, 35};

    // empty, extremes, ties at top and bottom, fill up, refused insert, drain a few
    add_row(REQ_REMOVE, 1023, 32'h3FFF_FFFF, 255, 1, ST_EMPTY, 0);
    add_row(REQ_INSERT, 0,    0,             0,   1, ST_OK, 1);
    add_row(REQ_INSERT, 1023, 32'h3FFF_FFFF, 255, 1, ST_OK, 2);
    add_row(REQ_INSERT, 512,  1,             1,   1, ST_OK, 3);
    add_row(REQ_INSERT, 512,  2,             2,   1, ST_OK, 4);
    add_row(REQ_INSERT, 1023, 3,             3,   1, ST_OK, 5);
    add_row(REQ_INSERT, 0,    4,             4,   1, ST_OK, 6);
    add_row(REQ_INSERT, 511,  999999999,     128, 1, ST_OK, 7);
    add_row(REQ_INSERT, 1,    5,             85,  1, ST_OK, 8);
    add_row(REQ_INSERT, 1022, 32'h2AAA_AAAA, 170, 1, ST_OK, 9);
    add_row(REQ_INSERT, 341,  32'h1555_5555, 7,   1, ST_OK, 10);
    add_row(REQ_INSERT, 682,  6,             254, 1, ST_OK, 11);
    add_row(REQ_INSERT, 512,  7,             64,  1, ST_OK, 12);
    add_row(REQ_INSERT, 1023, 8,             32,  1, ST_OK, 13);
    add_row(REQ_INSERT, 0,    9,             16,  1, ST_OK, 14);
    add_row(REQ_INSERT, 100,  10,            1,   1, ST_OK, 15);
    add_row(REQ_INSERT, 900,  11,            2,   1, ST_OK, 16);
    add_row(REQ_INSERT, 300,  99,            7,   1, ST_FULL, 16);
    add_row(REQ_REMOVE, 0, 0, 0, 0, ST_OK, 0);
    add_row(REQ_REMOVE, 0, 0, 0, 0, ST_OK, 0);
    add_row(REQ_REMOVE, 0, 0, 0, 0, ST_OK, 0);
    add_row(REQ_REMOVE, 0, 0, 0, 0, ST_OK, 0);
    add_row(REQ_INSERT, 1023, 12, 9, 1, ST_OK, 13);
    add_row(REQ_REMOVE, 0, 0, 0, 0, ST_OK, 0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      issue_request(dir_rows[i].rq, dir_rows[i].known, dir_rows[i].res, 0);
    end

    ins_pct = 50;
    for (int n = 0; n < N_RANDOM; n++) begin
      phase = n * 4 / N_RANDOM;
      // insert-heavy and remove-heavy stretches so the queue hits full and empty
      if (n % 40 == 0) ins_pct = $urandom_range(15, 85);
      r = req_t'({$urandom, $urandom});
      r.req_type = ($urandom_range(99) < ins_pct) ? REQ_INSERT : REQ_REMOVE;
      // narrow priorities half the time to get plenty of ties
      if ($urandom_range(1)) begin
        case ($urandom_range(3))
          0: r.priority_req = '0;
          1: r.priority_req = '1;
          2: r.priority_req = PRIO_W'(512);
          default: r.priority_req = PRIO_W'($urandom_range(3));
        endcase
      end
      issue_request(r, 0, '0, idle_pct[phase]);
    end
    start <= 1'b0;

    guard = 0;
    while (pending_results.size() != 0 && guard < 100) begin
      @(posedge clk);
      guard++;
    end
    repeat (5) @(posedge clk);

    if (pending_results.size() != 0) begin
      $display("%0t: %0d transactions never returned", $time, pending_results.size());
      err_cnt++;
    end

    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
